### hw/rtl/tea_bcm_pkg.sv
// Shared types and constants for the TEA block cipher with chaining modes.
// Used by the round cell and the top level; depends on nothing else.
package tea_bcm_pkg;

    // TEA round constant and default round count.
    localparam logic [31:0] TEA_DELTA  = 32'h9E3779B9;
    localparam int          DEF_ROUNDS = 32;

    // Configuration register indexes.
    localparam int          CFG_IDX_W   = 3;
    localparam logic [2:0]  REG_KEY0    = 3'd0;
    localparam logic [2:0]  REG_KEY1    = 3'd1;
    localparam logic [2:0]  REG_KEY2    = 3'd2;
    localparam logic [2:0]  REG_KEY3    = 3'd3;
    localparam logic [2:0]  REG_IV      = 3'd4;
    localparam logic [2:0]  REG_MODE    = 3'd5;
    localparam logic [2:0]  REG_DECRYPT = 3'd6;

    // Chaining mode codes.
    localparam logic [2:0]  MODE_ECB  = 3'd0;
    localparam logic [2:0]  MODE_CBC  = 3'd1;
    localparam logic [2:0]  MODE_PCBC = 3'd2;
    localparam logic [2:0]  MODE_CFB  = 3'd3;
    localparam logic [2:0]  MODE_OFB  = 3'd4;

    // The 128-bit key as four words.
    typedef struct packed {
        logic [31:0] k3;
        logic [31:0] k2;
        logic [31:0] k1;
        logic [31:0] k0;
    } t_key;

    // What travels down the row of round cells with each block.
    typedef struct packed {
        logic [31:0] v1;    // high cipher word
        logic [31:0] v0;    // low cipher word
        logic [63:0] post;  // value xored onto the cipher output
        logic [63:0] x;     // block as it came in
        logic        last;  // end of message flag
    } t_stage;

endpackage

### hw/rtl/tea_block_cipher_modes.sv
// TEA block cipher (ECB, CBC, PCBC, CFB, OFB) built as a row of ROUNDS round cells.
// An accepted block passes through the ROUNDS round cell registers, then the output register.
// Throughput: ECB and CBC/CFB decryption take one block per cycle unless output stalls;
// CBC/CFB encryption, PCBC and OFB take a new block only when the previous one leaves the
// cell row, as the chain value feeds back from the end of the cell row to its start.
// Reset (synchronous): keys, IV, mode and direction clear; the chain reloads from the IV.
module tea_block_cipher_modes #(
    parameter int ROUNDS = tea_bcm_pkg::DEF_ROUNDS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tea_bcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                       i_cfg_data,
    // Input block channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [63:0]                       i_block_in,
    input  logic                              i_last_in,
    // Output block channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [63:0]                       o_block_out,
    output logic                              o_last_out
);
    import tea_bcm_pkg::*;

    // Configuration registers.
    t_key        r_key;
    logic [63:0] r_iv;
    logic [2:0]  r_mode;
    logic        r_dec;

    // Chaining state.
    logic [63:0] r_chain;
    logic [63:0] n_chain;
    logic        r_restart;
    logic        r_busy;

    // Output register.
    logic        r_out_valid;
    logic [63:0] r_out_block;
    logic        r_out_last;

    // Cell row connections; entry 0 is the block entering the row.
    logic        st_valid [ROUNDS+1];
    t_stage      st_data  [ROUNDS+1];

    logic        core_dec;
    logic        fb_mode;
    logic        ff_in;
    logic        advance;
    logic        out_load;
    logic        move_out;
    logic        in_accept;
    logic [63:0] core_out;
    logic [63:0] y_out;
    logic [63:0] fb_chain;
    logic [63:0] chain_now;
    logic [63:0] v_eff;
    t_stage      entry;

    assign o_cfg_ready = 1'b1;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_iv   <= '0;
            r_mode <= MODE_ECB;
            r_dec  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY0:    r_key.k0 <= i_cfg_data[31:0];
                REG_KEY1:    r_key.k1 <= i_cfg_data[31:0];
                REG_KEY2:    r_key.k2 <= i_cfg_data[31:0];
                REG_KEY3:    r_key.k3 <= i_cfg_data[31:0];
                REG_IV:      r_iv     <= i_cfg_data;
                REG_MODE:    r_mode   <= i_cfg_data[2:0];
                REG_DECRYPT: r_dec    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Mode decode: core direction, and whether the chain needs the block's result
    // (feedback) or only its input (feed forward).
    always_comb begin
        core_dec = r_dec;
        fb_mode  = 1'b0;
        ff_in    = 1'b0;
        unique case (r_mode)
            MODE_CBC: begin
                fb_mode = !r_dec;
                ff_in   = r_dec;
            end
            MODE_PCBC: fb_mode = 1'b1;
            MODE_CFB: begin
                core_dec = 1'b0;
                fb_mode  = !r_dec;
                ff_in    = r_dec;
            end
            MODE_OFB: begin
                core_dec = 1'b0;
                fb_mode  = 1'b1;
            end
            default: ;
        endcase
    end

    // Handshake: the row shifts unless a finished block is stuck behind a full output.
    assign out_load  = !r_out_valid || i_out_ready;
    assign advance   = !st_valid[ROUNDS] || out_load;
    assign move_out  = advance && st_valid[ROUNDS];
    assign o_in_ready = advance && (!r_busy || move_out);
    assign in_accept = i_in_valid && o_in_ready;

    // Result at the end of the row, and the chain value it produces in feedback modes.
    assign core_out = {st_data[ROUNDS].v1, st_data[ROUNDS].v0};
    assign y_out    = core_out ^ st_data[ROUNDS].post;

    always_comb begin
        case (r_mode)
            MODE_PCBC: fb_chain = st_data[ROUNDS].x ^ y_out;
            MODE_OFB:  fb_chain = core_out;
            default:   fb_chain = y_out;
        endcase
    end

    // The chain value seen by an entering block, with the leaving block's update bypassed.
    assign chain_now = (move_out && fb_mode) ? fb_chain : r_chain;
    assign v_eff     = r_restart ? r_iv : chain_now;

    // Build the entry of the row for the current mode.
    always_comb begin
        entry.x    = i_block_in;
        entry.last = i_last_in;
        entry.post = '0;
        {entry.v1, entry.v0} = i_block_in;
        unique case (r_mode) inside
            MODE_CBC, MODE_PCBC: begin
                if (r_dec) begin
                    entry.post = v_eff;
                end else begin
                    {entry.v1, entry.v0} = i_block_in ^ v_eff;
                end
            end
            MODE_CFB, MODE_OFB: begin
                {entry.v1, entry.v0} = v_eff;
                entry.post = i_block_in;
            end
            default: ;
        endcase
    end

    assign st_valid[0] = in_accept;
    assign st_data[0]  = entry;

    // The row of round cells.
    for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
        tea_bcm_round_cell #(
            .ROUNDS    (ROUNDS),
            .ROUND_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_advance  (advance),
            .i_core_dec (core_dec),
            .i_key      (r_key),
            .i_valid    (st_valid[g]),
            .i_data     (st_data[g]),
            .o_valid    (st_valid[g+1]),
            .o_data     (st_data[g+1])
        );
    end

    // Chain update: the leaving block first, then the entering block, in that order.
    always_comb begin
        n_chain = r_chain;
        if (move_out && fb_mode) begin
            n_chain = fb_chain;
        end
        if (in_accept) begin
            n_chain = ff_in ? i_block_in : v_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain   <= '0;
            r_restart <= 1'b1;
            r_busy    <= 1'b0;
        end else begin
            r_chain <= n_chain;
            if (in_accept) begin
                r_restart <= i_last_in;
            end
            if (in_accept && fb_mode) begin
                r_busy <= 1'b1;
            end else if (move_out) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Output register; it takes the next result as soon as the current one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= st_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_out) begin
            r_out_block <= y_out;
            r_out_last  <= st_data[ROUNDS].last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_block_out = r_out_block;
    assign o_last_out  = r_out_last;

endmodule

### hw/rtl/tea_bcm_round_cell.sv
// One TEA round with its pipeline register; one cell of the round row.
// Depends on tea_bcm_pkg for the stage and key types and the round constant.
module tea_bcm_round_cell #(
    parameter int ROUNDS    = tea_bcm_pkg::DEF_ROUNDS,
    parameter int ROUND_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_core_dec,
    input  tea_bcm_pkg::t_key    i_key,
    input  logic                 i_valid,
    input  tea_bcm_pkg::t_stage  i_data,
    output logic                 o_valid,
    output tea_bcm_pkg::t_stage  o_data
);
    import tea_bcm_pkg::*;

    // Round sums are fixed per cell: counting up when encrypting, down when decrypting.
    localparam logic [63:0] ENC_SUM_W = 64'(TEA_DELTA) * 64'(ROUND_IDX + 1);
    localparam logic [63:0] DEC_SUM_W = 64'(TEA_DELTA) * 64'(ROUNDS - ROUND_IDX);
    localparam logic [31:0] ENC_SUM   = ENC_SUM_W[31:0];
    localparam logic [31:0] DEC_SUM   = DEC_SUM_W[31:0];

    function automatic logic [31:0] tea_mix(
        input logic [31:0] v,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    // The round itself: two half rounds, the second using the first's result.
    always_comb begin
        n_data = i_data;
        if (i_core_dec) begin
            n_data.v1 = i_data.v1 - tea_mix(i_data.v0, DEC_SUM, i_key.k2, i_key.k3);
            n_data.v0 = i_data.v0 - tea_mix(n_data.v1, DEC_SUM, i_key.k0, i_key.k1);
        end else begin
            n_data.v0 = i_data.v0 + tea_mix(i_data.v1, ENC_SUM, i_key.k0, i_key.k1);
            n_data.v1 = i_data.v1 + tea_mix(n_data.v0, ENC_SUM, i_key.k2, i_key.k3);
        end
    end

    // Valid bit is reset; the payload only loads when a block moves in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### dv/tea_block_cipher_modes_test.sv
// Self-checking testbench for the TEA block cipher with ECB, CBC, PCBC, CFB and OFB chaining.
// Keeps its own cipher and chaining model and checks every output block against it.
// Depends on tea_bcm_pkg and tea_block_cipher_modes only.
module tea_block_cipher_modes_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tea_bcm_pkg::*;

    localparam int         NUM_ROUNDS    = DEF_ROUNDS;
    localparam int         RANDOM_ITEMS  = 1700;
    // Index 7 lies beyond the register map and must be ignored.
    localparam logic [2:0] REG_UNUSED    = 3'd7;
    // Mode codes past OFB behave as ECB and leave the chain alone.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [63:0] blk;
        logic        last;
    } t_cipher_result;

    // Block ports.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [63:0]          i_block_in  = '0;
    logic                 i_last_in   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [63:0]          o_block_out;
    logic                 o_last_out;

    // Shadow copy of the configuration and the chaining state.
    logic [31:0]    shadow_key [4];
    logic [63:0]    shadow_iv;
    logic [2:0]     shadow_mode;
    logic           shadow_decrypt;
    logic [63:0]    chain_value;
    logic           msg_restart;

    t_cipher_result cipher_expect_q [$];
    int             err_count          = 0;
    int             burst_left         = 0;
    int             stall_left         = 0;
    bit             sender_gaps_on     = 1'b0;
    bit             receiver_stalls_on = 1'b0;

    tea_block_cipher_modes #(
        .ROUNDS (NUM_ROUNDS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_block_in  (i_block_in),
        .i_last_in   (i_last_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_block_out (o_block_out),
        .o_last_out  (o_last_out)
    );

    // Clock: 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // One half-round of TEA.
    function automatic logic [31:0] tea_mix(logic [31:0] v, logic [31:0] sum,
                                            logic [31:0] ka, logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    function automatic logic [63:0] tea_encrypt(logic [63:0] blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        v0  = blk[31:0];
        v1  = blk[63:32];
        sum = '0;
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            sum += TEA_DELTA;
            v0  += tea_mix(v1, sum, shadow_key[0], shadow_key[1]);
            v1  += tea_mix(v0, sum, shadow_key[2], shadow_key[3]);
        end
        return {v1, v0};
    endfunction

    function automatic logic [63:0] tea_decrypt(logic [63:0] blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        v0  = blk[31:0];
        v1  = blk[63:32];
        sum = '0;
        repeat (NUM_ROUNDS) sum += TEA_DELTA;
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            v1  -= tea_mix(v0, sum, shadow_key[2], shadow_key[3]);
            v0  -= tea_mix(v1, sum, shadow_key[0], shadow_key[1]);
            sum -= TEA_DELTA;
        end
        return {v1, v0};
    endfunction

    // Work out the output block for one accepted input and advance the chain.
    task automatic predict_cipher(input logic [63:0] x, input logic last);
        t_cipher_result res;
        logic [63:0]    y;
        if (msg_restart) begin
            chain_value = shadow_iv;
            msg_restart = 1'b0;
        end
        case (shadow_mode)
            MODE_CBC: begin
                if (shadow_decrypt) begin
                    y           = tea_decrypt(x) ^ chain_value;
                    chain_value = x;
                end else begin
                    y           = tea_encrypt(x ^ chain_value);
                    chain_value = y;
                end
            end
            MODE_PCBC: begin
                if (shadow_decrypt) y = tea_decrypt(x) ^ chain_value;
                else                y = tea_encrypt(x ^ chain_value);
                chain_value = x ^ y;
            end
            MODE_CFB: begin
                y           = x ^ tea_encrypt(chain_value);
                chain_value = shadow_decrypt ? x : y;
            end
            MODE_OFB: begin
                chain_value = tea_encrypt(chain_value);
                y           = x ^ chain_value;
            end
            default: begin
                y = shadow_decrypt ? tea_decrypt(x) : tea_encrypt(x);
            end
        endcase
        if (last) msg_restart = 1'b1;
        res.blk  = y;
        res.last = last;
        cipher_expect_q.push_back(res);
    endtask

    // Mirror a register write in the shadow configuration.
    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            REG_KEY0:    shadow_key[0]  = data[31:0];
            REG_KEY1:    shadow_key[1]  = data[31:0];
            REG_KEY2:    shadow_key[2]  = data[31:0];
            REG_KEY3:    shadow_key[3]  = data[31:0];
            REG_IV:      shadow_iv      = data;
            REG_MODE:    shadow_mode    = data[2:0];
            REG_DECRYPT: shadow_decrypt = data[0];
            default: ;
        endcase
    endtask

    // Mostly random values, with the all-zero and all-one extremes now and then.
    function automatic logic [63:0] pick_wide();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A random write value for one register; spare mode codes turn up now and then.
    function automatic logic [63:0] config_value(int idx);
        logic [63:0] noise;
        logic [2:0]  mode;
        noise = {$urandom, $urandom};
        if ($urandom_range(0, 5) == 0) mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        else                           mode = 3'($urandom_range(MODE_ECB, MODE_OFB));
        case (idx)
            REG_MODE:    return {noise[63:3], mode};
            REG_DECRYPT: return noise;
            default:     return pick_wide();
        endcase
    endfunction

    // One configuration transaction.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One input transaction; valid stays high through a burst and drops for the gaps.
    task automatic send_block(input logic [63:0] blk, input logic last);
        int gap;
        i_in_valid <= 1'b1;
        i_block_in <= blk;
        i_last_in  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_cipher(blk, last);
        if (sender_gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop sending, let every expected block arrive, then allow the pipeline to empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (cipher_expect_q.size() != 0) @(posedge i_clk);
        repeat (NUM_ROUNDS + 8) @(posedge i_clk);
    endtask

    // Output checker and receiver stall pattern.
    always @(posedge i_clk) begin : out_check
        t_cipher_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_expect_q.size() == 0) begin
                $display("%0t: unexpected output transaction: expected none, actual %h last %b",
                         $time, o_block_out, o_last_out);
                err_count++;
            end else begin
                exp_res = cipher_expect_q.pop_front();
                if (o_block_out !== exp_res.blk) begin
                    $display("%0t: block_out mismatch: expected %h, actual %h",
                             $time, exp_res.blk, o_block_out);
                    err_count++;
                end
                if (o_last_out !== exp_res.last) begin
                    $display("%0t: last_out mismatch: expected %b, actual %b",
                             $time, exp_res.last, o_last_out);
                    err_count++;
                end
            end
        end
        if (!receiver_stalls_on) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Blocks straight out of reset: zero key, zero IV, ECB encryption.
    task automatic test_reset_state();
        send_block('0, 1'b0);
        send_block('1, 1'b1);
    endtask

    // Every mode in both directions inside one message, so the chain is carried
    // across mode and direction changes; the IV is rewritten halfway through.
    task automatic test_mode_sweep();
        logic [63:0] patterns [4];
        int          n;
        patterns = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
        n        = 0;
        wait_idle();
        write_register(REG_KEY0, '1);
        write_register(REG_KEY1, '0);
        write_register(REG_KEY2, 64'hFFFF_FFFF_A5A5_5A5A);
        write_register(REG_KEY3, 64'h0123_4567_89AB_CDEF);
        write_register(REG_IV, 64'hFEDC_BA98_7654_3210);
        for (int m = MODE_ECB; m <= MODE_OFB; m++) begin
            for (int d = 0; d < 2; d++) begin
                wait_idle();
                write_register(REG_MODE, {61'h1FFF_FFFF_FFFF_FFFF, 3'(m)});
                write_register(REG_DECRYPT, {63'h0, 1'(d)});
                if (m == MODE_PCBC && d == 1) write_register(REG_IV, '1);
                send_block(patterns[n % 4], 1'b0);
                n++;
            end
        end
        send_block({$urandom, $urandom}, 1'b1);
    endtask

    // Spare mode codes act as ECB and must leave a CBC chain untouched;
    // a write to the unused index must change nothing.
    task automatic test_spare_codes();
        wait_idle();
        write_register(REG_UNUSED, '1);
        write_register(REG_MODE, {61'h0, MODE_CBC});
        write_register(REG_DECRYPT, '0);
        send_block({$urandom, $urandom}, 1'b0);
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
            wait_idle();
            write_register(REG_MODE, {61'h0, 3'(m)});
            send_block({$urandom, $urandom}, 1'b0);
        end
        wait_idle();
        write_register(REG_MODE, {61'h0, MODE_CBC});
        send_block({$urandom, $urandom}, 1'b1);
    endtask

    // Random messages in phases with fresh settings; phases often end mid-message,
    // so settings also change while a chain is in flight.
    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int msg_left;
        bit noisy;
        sent     = 0;
        msg_left = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            sender_gaps_on     = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            for (int i = REG_KEY0; i <= REG_DECRYPT; i++) begin
                if (sent == 0 || $urandom_range(0, 2) == 0) begin
                    write_register(CFG_IDX_W'(i), config_value(i));
                end
            end
            if ($urandom_range(0, 9) == 0) write_register(REG_UNUSED, pick_wide());
            phase_len = $urandom_range(20, 90);
            noisy     = ($urandom_range(0, 7) == 0);
            repeat (phase_len) begin
                if (msg_left == 0) msg_left = $urandom_range(1, 8);
                msg_left--;
                if (noisy) send_block(pick_wide(), $urandom_range(0, 1) == 1);
                else       send_block(pick_wide(), msg_left == 0);
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        shadow_key     = '{default: '0};
        shadow_iv      = '0;
        shadow_mode    = MODE_ECB;
        shadow_decrypt = 1'b0;
        chain_value    = '0;
        msg_restart    = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        test_reset_state();
        test_mode_sweep();
        test_spare_codes();
        test_random_traffic();
        wait_idle();

        if (err_count == 0) $display("CHECK OK");
        else                $display("CHECK FAILED");
        $finish;
    end

    // Watchdog in case the block hangs.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
